[rtl/weighted_work_apportioner_core_assert.svh]
// ---------------------------------------------------------------------------
// Assertion macros for the weighted work apportioner
// Clocked on clk_i and disabled while rst_ni is low.
// ---------------------------------------------------------------------------
`ifndef WEIGHTED_WORK_APPORTIONER_CORE_ASSERT_SVH
`define WEIGHTED_WORK_APPORTIONER_CORE_ASSERT_SVH

// Check a property on every rising edge of clk_i outside reset.
`define WWA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check that the antecedent implies the consequent in the same cycle.
`define WWA_ASSERT_IMPL(lbl, ante, cons, msg) \
  `WWA_ASSERT(lbl, (ante) |-> (cons), msg)

`endif

[rtl/wwa_pkg.sv]
// ---------------------------------------------------------------------------
// wwa_pkg
// Types and constants shared by the weighted work apportioner files.
// ---------------------------------------------------------------------------
`default_nettype none

package wwa_pkg;

  localparam logic [1:0] OP_REGISTER   = 2'd0;
  localparam logic [1:0] OP_UNREGISTER = 2'd1;
  localparam logic [1:0] OP_SCHEDULE   = 2'd2;
  localparam logic [1:0] OP_RESERVED   = 2'd3;

  localparam logic [4:0] RESULT_LIMIT  = 5'd16;
  localparam logic [4:0] CFG_RESET     = 5'd16;

  typedef struct packed {
    logic [1:0]  op;
    logic [31:0] wrk_id;
    logic [2:0]  backend;
    logic [31:0] rate;
    logic [31:0] work_total;
  } in_item_t;

  typedef struct packed {
    logic        status;
    logic [31:0] assigned_worker;
    logic [2:0]  assigned_backend;
    logic [31:0] range_base;
    logic [31:0] range_len;
    logic [31:0] assigned_rate;
    logic [4:0]  assignment_total;
    logic        last;
  } out_item_t;

  // One row of the worker table.
  typedef struct packed {
    logic [31:0] id;
    logic [2:0]  backend;
    logic [31:0] rate;
  } entry_t;

endpackage

`default_nettype wire

[rtl/weighted_work_apportioner_core.sv]
// ---------------------------------------------------------------------------
// weighted_work_apportioner_core
// Worker table with register/unregister and largest-remainder scheduling.
// ---------------------------------------------------------------------------
//  channel  | signals                          | direction
//  ---------+----------------------------------+----------
//  in       | in_valid_i, in_ready_o, in_data_i | to core
//  out      | out_valid_o, out_ready_i, out_data_o | from core
//  cfg      | cfg_we_i, cfg_wdata_i            | to core
//
// One item at a time; in_ready_o is high only while the sequencer is idle.
// Register/unregister: one table scan. Schedule: a sum pass, a divide pass
// that runs a restoring divider for each candidate and skips the others,
// one table scan per leftover unit, a count pass, then an emit pass over
// the table rows up to the last result, held by output stalls. Every table
// access goes through a registered RAM read. Reset clears the fill count,
// the output valid and the sequencer; the table RAM needs no clear.
// A full output register stalls the sequencer; the input side is held off.
// ---------------------------------------------------------------------------
`default_nettype none

module weighted_work_apportioner_core
  import wwa_pkg::*;
#(
  parameter int MAX_WORKERS = 16
) (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_ready_o,
  input  wire in_item_t  in_data_i,
  output logic           out_valid_o,
  input  wire logic      out_ready_i,
  output out_item_t      out_data_o,
  input  wire logic      cfg_we_i,
  input  wire logic [4:0] cfg_wdata_i
);

  localparam int CW  = $clog2(MAX_WORKERS + 1);
  localparam int IW  = (MAX_WORKERS > 1) ? $clog2(MAX_WORKERS) : 1;
  localparam int SW  = 32 + $clog2(MAX_WORKERS);
  localparam int SCW = 32 + SW + 1;
  localparam int EW  = $bits(entry_t);

  localparam logic [4:0] S_IDLE     = 5'd0;
  localparam logic [4:0] S_FIND_RD  = 5'd1;
  localparam logic [4:0] S_FIND_CHK = 5'd2;
  localparam logic [4:0] S_REG_ADD  = 5'd3;
  localparam logic [4:0] S_MOVE_RD  = 5'd4;
  localparam logic [4:0] S_MOVE_WR  = 5'd5;
  localparam logic [4:0] S_SUM_RD   = 5'd6;
  localparam logic [4:0] S_SUM_CHK  = 5'd7;
  localparam logic [4:0] S_DIV_RD   = 5'd8;
  localparam logic [4:0] S_DIV_MUL  = 5'd9;
  localparam logic [4:0] S_DIV_IT   = 5'd10;
  localparam logic [4:0] S_DIV_WR   = 5'd11;
  localparam logic [4:0] S_LO_RD    = 5'd12;
  localparam logic [4:0] S_LO_CHK   = 5'd13;
  localparam logic [4:0] S_LO_WR    = 5'd14;
  localparam logic [4:0] S_CNT_RD   = 5'd15;
  localparam logic [4:0] S_CNT_CHK  = 5'd16;
  localparam logic [4:0] S_EM_RD    = 5'd17;
  localparam logic [4:0] S_EM_CHK   = 5'd18;
  localparam logic [4:0] S_RESP     = 5'd19;

  // Control state
  logic [4:0]    state_q, state_d;
  logic [CW-1:0] count_q, count_d;
  logic [4:0]    cfg_q, cfg_d;
  logic          out_valid_q, out_valid_d;

  // Item and working registers
  logic [1:0]    op_q, op_d;
  logic [31:0]   id_q, id_d;
  logic [2:0]    be_q, be_d;
  logic [31:0]   rate_q, rate_d;
  logic [31:0]   total_q, total_d;
  logic [CW-1:0] idx_q, idx_d;
  logic [IW-1:0] hit_q, hit_d;
  logic [CW-1:0] nc_q, nc_d;
  logic [SW-1:0] sum_q, sum_d;
  logic [SW-1:0] drem_q, drem_d;
  logic [31:0]   quo_q, quo_d;
  logic [4:0]    it_q, it_d;
  logic [31:0]   asg_q, asg_d;
  logic [31:0]   left_q, left_d;
  logic          found_q, found_d;
  logic [IW-1:0] best_idx_q, best_idx_d;
  logic [SW-1:0] best_rem_q, best_rem_d;
  logic [31:0]   best_id_q, best_id_d;
  logic [31:0]   best_units_q, best_units_d;
  logic [CW-1:0] n_q, n_d;
  logic [CW-1:0] emit_q, emit_d;
  logic [31:0]   first_q, first_d;
  logic          err_q, err_d;
  out_item_t     out_q, out_d;

  // RAM ports
  logic           tbl_we, tbl_re;
  logic [IW-1:0]  tbl_waddr, rd_addr;
  entry_t         tbl_wdata, tbl_rd;
  logic           scr_we;
  logic [IW-1:0]  scr_waddr;
  logic [SCW-1:0] scr_wdata, scr_rd;

  // Scratch row fields
  logic [31:0]    scr_units;
  logic [SW-1:0]  scr_rem;
  logic           scr_used;

  logic           idx_last, out_free, cand;
  logic [CW-1:0]  idx_inc;
  logic [4:0]     cap;
  logic [63:0]    prod;
  logic [SW:0]    div_t;
  logic           div_ge;
  logic [SW-1:0]  div_r;
  logic [31:0]    asg_now;
  logic [31:0]    left_now;
  logic [CW-1:0]  nc_now;
  logic [SW-1:0]  sum_now;

  wwa_ram #(.WIDTH(EW), .DEPTH(MAX_WORKERS)) u_tbl_ram (
    .clk_i   (clk_i),
    .we_i    (tbl_we),
    .waddr_i (tbl_waddr),
    .wdata_i (tbl_wdata),
    .re_i    (tbl_re),
    .raddr_i (rd_addr),
    .rdata_o (tbl_rd)
  );

  wwa_ram #(.WIDTH(SCW), .DEPTH(MAX_WORKERS)) u_scr_ram (
    .clk_i   (clk_i),
    .we_i    (scr_we),
    .waddr_i (scr_waddr),
    .wdata_i (scr_wdata),
    .re_i    (tbl_re),
    .raddr_i (rd_addr),
    .rdata_o (scr_rd)
  );

  assign scr_units = scr_rd[SCW-1 -: 32];
  assign scr_rem   = scr_rd[SW:1];
  assign scr_used  = scr_rd[0];

  assign idx_inc  = idx_q + CW'(1);
  assign idx_last = (idx_inc == count_q);
  assign out_free = !out_valid_q || out_ready_i;
  assign cand     = (tbl_rd.backend != 3'd0);
  assign cap      = (cfg_q > RESULT_LIMIT) ? RESULT_LIMIT : cfg_q;
  assign prod     = total_q * tbl_rd.rate;

  // One restoring divide step: shift in the next dividend bit, subtract if it fits.
  assign div_t  = {drem_q, quo_q[31]};
  assign div_ge = (div_t >= {1'b0, sum_q});
  assign div_r  = div_ge ? SW'(div_t - {1'b0, sum_q}) : div_t[SW-1:0];

  assign nc_now  = nc_q + (cand ? CW'(1) : CW'(0));
  assign sum_now = sum_q + (cand ? SW'(tbl_rd.rate) : SW'(0));

  always_comb begin
    state_d      = state_q;
    count_d      = count_q;
    op_d         = op_q;
    id_d         = id_q;
    be_d         = be_q;
    rate_d       = rate_q;
    total_d      = total_q;
    idx_d        = idx_q;
    hit_d        = hit_q;
    nc_d         = nc_q;
    sum_d        = sum_q;
    drem_d       = drem_q;
    quo_d        = quo_q;
    it_d         = it_q;
    asg_d        = asg_q;
    left_d       = left_q;
    found_d      = found_q;
    best_idx_d   = best_idx_q;
    best_rem_d   = best_rem_q;
    best_id_d    = best_id_q;
    best_units_d = best_units_q;
    n_d          = n_q;
    emit_d       = emit_q;
    first_d      = first_q;
    err_d        = err_q;
    out_d        = out_q;
    out_valid_d  = out_valid_q && !out_ready_i;
    in_ready_o   = 1'b0;
    tbl_we       = 1'b0;
    tbl_waddr    = idx_q[IW-1:0];
    tbl_wdata    = '{id: id_q, backend: be_q, rate: rate_q};
    tbl_re       = 1'b0;
    rd_addr      = idx_q[IW-1:0];
    scr_we       = 1'b0;
    scr_waddr    = idx_q[IW-1:0];
    scr_wdata    = {quo_q, drem_q, 1'b0};
    asg_now      = asg_q;
    left_now     = '0;

    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          op_d    = in_data_i.op;
          id_d    = in_data_i.wrk_id;
          be_d    = in_data_i.backend;
          rate_d  = (in_data_i.rate == 32'd0) ? 32'd1 : in_data_i.rate;
          total_d = in_data_i.work_total;
          idx_d   = '0;
          nc_d    = '0;
          sum_d   = '0;
          priority if (in_data_i.op == OP_REGISTER || in_data_i.op == OP_UNREGISTER) begin
            priority if (in_data_i.wrk_id == 32'd0) begin
              err_d   = 1'b1;
              state_d = S_RESP;
            end else if (count_q == '0) begin
              err_d   = 1'b1;
              state_d = (in_data_i.op == OP_REGISTER) ? S_REG_ADD : S_RESP;
            end else begin
              state_d = S_FIND_RD;
            end
          end else if (in_data_i.op == OP_SCHEDULE) begin
            err_d   = 1'b0;
            state_d = (in_data_i.work_total == 32'd0 || count_q == '0) ? S_RESP : S_SUM_RD;
          end else begin
            err_d   = 1'b1;
            state_d = S_RESP;
          end
        end
      end

      S_FIND_RD: begin
        tbl_re  = 1'b1;
        state_d = S_FIND_CHK;
      end

      S_FIND_CHK: begin
        priority if (tbl_rd.id == id_q) begin
          if (op_q == OP_REGISTER) begin
            // Update an existing worker in place.
            tbl_we  = 1'b1;
            err_d   = 1'b0;
            state_d = S_RESP;
          end else begin
            hit_d   = idx_q[IW-1:0];
            state_d = S_MOVE_RD;
          end
        end else if (idx_last) begin
          err_d   = 1'b1;
          state_d = (op_q == OP_REGISTER) ? S_REG_ADD : S_RESP;
        end else begin
          idx_d   = idx_inc;
          state_d = S_FIND_RD;
        end
      end

      S_REG_ADD: begin
        if (count_q == CW'(MAX_WORKERS)) begin
          err_d = 1'b1;
        end else begin
          tbl_we    = 1'b1;
          tbl_waddr = count_q[IW-1:0];
          count_d   = count_q + CW'(1);
          err_d     = 1'b0;
        end
        state_d = S_RESP;
      end

      S_MOVE_RD: begin
        // Fetch the last row to fill the hole.
        tbl_re  = 1'b1;
        rd_addr = IW'(count_q - CW'(1));
        state_d = S_MOVE_WR;
      end

      S_MOVE_WR: begin
        tbl_we    = 1'b1;
        tbl_waddr = hit_q;
        tbl_wdata = tbl_rd;
        count_d   = count_q - CW'(1);
        err_d     = 1'b0;
        state_d   = S_RESP;
      end

      S_SUM_RD: begin
        tbl_re  = 1'b1;
        state_d = S_SUM_CHK;
      end

      S_SUM_CHK: begin
        nc_d  = nc_now;
        sum_d = sum_now;
        if (idx_last) begin
          idx_d = '0;
          asg_d = '0;
          priority if (nc_now == '0) begin
            err_d   = 1'b0;
            state_d = S_RESP;
          end else if (nc_now > cap) begin
            err_d   = 1'b1;
            state_d = S_RESP;
          end else begin
            state_d = S_DIV_RD;
          end
        end else begin
          idx_d   = idx_inc;
          state_d = S_SUM_RD;
        end
      end

      S_DIV_RD: begin
        tbl_re  = 1'b1;
        state_d = S_DIV_MUL;
      end

      S_DIV_MUL, S_DIV_WR: begin
        if (state_q == S_DIV_MUL && cand) begin
          // Quotient fits in 32 bits, so the high half starts below the divisor.
          drem_d  = SW'(prod[63:32]);
          quo_d   = prod[31:0];
          it_d    = '0;
          state_d = S_DIV_IT;
        end else begin
          if (state_q == S_DIV_WR) begin
            scr_we  = 1'b1;
            asg_now = asg_q + quo_q;
            asg_d   = asg_now;
          end
          if (idx_last) begin
            left_now = total_q - asg_now;
            left_d   = left_now;
            idx_d    = '0;
            found_d  = 1'b0;
            n_d      = '0;
            state_d  = (left_now == 32'd0) ? S_CNT_RD : S_LO_RD;
          end else begin
            idx_d   = idx_inc;
            state_d = S_DIV_RD;
          end
        end
      end

      S_DIV_IT: begin
        drem_d = div_r;
        quo_d  = {quo_q[30:0], div_ge};
        it_d   = it_q + 5'd1;
        if (it_q == 5'd31) begin
          state_d = S_DIV_WR;
        end
      end

      S_LO_RD: begin
        tbl_re  = 1'b1;
        state_d = S_LO_CHK;
      end

      S_LO_CHK: begin
        // Track the largest remainder not yet bumped; ties go to the lower id.
        if (cand && !scr_used && (!found_q || scr_rem > best_rem_q ||
            (scr_rem == best_rem_q && tbl_rd.id < best_id_q))) begin
          found_d      = 1'b1;
          best_idx_d   = idx_q[IW-1:0];
          best_rem_d   = scr_rem;
          best_id_d    = tbl_rd.id;
          best_units_d = scr_units;
        end
        if (idx_last) begin
          state_d = S_LO_WR;
        end else begin
          idx_d   = idx_inc;
          state_d = S_LO_RD;
        end
      end

      S_LO_WR: begin
        idx_d   = '0;
        found_d = 1'b0;
        if (found_q) begin
          scr_we    = 1'b1;
          scr_waddr = best_idx_q;
          scr_wdata = {best_units_q + 32'd1, best_rem_q, 1'b1};
          left_d    = left_q - 32'd1;
          state_d   = (left_q == 32'd1) ? S_CNT_RD : S_LO_RD;
        end else begin
          state_d = S_CNT_RD;
        end
      end

      S_CNT_RD: begin
        tbl_re  = 1'b1;
        state_d = S_CNT_CHK;
      end

      S_CNT_CHK: begin
        if (cand && scr_units != 32'd0) begin
          n_d = n_q + CW'(1);
        end
        if (idx_last) begin
          idx_d   = '0;
          emit_d  = '0;
          first_d = '0;
          state_d = S_EM_RD;
        end else begin
          idx_d   = idx_inc;
          state_d = S_CNT_RD;
        end
      end

      S_EM_RD: begin
        tbl_re  = 1'b1;
        state_d = S_EM_CHK;
      end

      S_EM_CHK: begin
        if (cand && scr_units != 32'd0) begin
          // Hold here until the output register frees up.
          if (out_free) begin
            out_valid_d               = 1'b1;
            out_d.status              = 1'b0;
            out_d.assigned_worker     = tbl_rd.id;
            out_d.assigned_backend    = tbl_rd.backend;
            out_d.range_base          = first_q;
            out_d.range_len           = scr_units;
            out_d.assigned_rate       = tbl_rd.rate;
            out_d.assignment_total    = 5'(n_q);
            out_d.last                = (emit_q + CW'(1) == n_q);
            first_d                   = first_q + scr_units;
            emit_d                    = emit_q + CW'(1);
            if (emit_q + CW'(1) == n_q) begin
              state_d = S_IDLE;
            end else begin
              idx_d   = idx_inc;
              state_d = S_EM_RD;
            end
          end
        end else begin
          idx_d   = idx_inc;
          state_d = S_EM_RD;
        end
      end

      S_RESP: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_d       = '0;
          out_d.status = err_q;
          out_d.last   = 1'b1;
          state_d      = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase

    if (cfg_we_i) begin
      cfg_d = cfg_wdata_i;
    end else begin
      cfg_d = cfg_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      cfg_q       <= CFG_RESET;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      cfg_q       <= cfg_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q         <= op_d;
    id_q         <= id_d;
    be_q         <= be_d;
    rate_q       <= rate_d;
    total_q      <= total_d;
    idx_q        <= idx_d;
    hit_q        <= hit_d;
    nc_q         <= nc_d;
    sum_q        <= sum_d;
    drem_q       <= drem_d;
    quo_q        <= quo_d;
    it_q         <= it_d;
    asg_q        <= asg_d;
    left_q       <= left_d;
    found_q      <= found_d;
    best_idx_q   <= best_idx_d;
    best_rem_q   <= best_rem_d;
    best_id_q    <= best_id_d;
    best_units_q <= best_units_d;
    n_q          <= n_d;
    emit_q       <= emit_d;
    first_q      <= first_d;
    err_q        <= err_d;
    out_q        <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`include "weighted_work_apportioner_core_assert.svh"

  `WWA_ASSERT(a_count_bound, count_q <= CW'(MAX_WORKERS), "table fill count overflow")
  `WWA_ASSERT(a_count_src, (count_q == $past(count_q)) ||
              ($past(state_q) == S_REG_ADD) || ($past(state_q) == S_MOVE_WR),
              "fill count changed outside add or move")
  `WWA_ASSERT_IMPL(a_left_bound, state_q == S_LO_RD, left_q < nc_q,
                   "leftover units not below candidate count")
  `WWA_ASSERT_IMPL(a_emit_bound, state_q == S_EM_CHK, emit_q < n_q,
                   "emitting past the result count")

endmodule

`default_nettype wire

[rtl/wwa_ram.sv]
// ---------------------------------------------------------------------------
// wwa_ram
// Simple dual-port RAM, one write and one registered read port.
// ---------------------------------------------------------------------------
`default_nettype none

module wwa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Read data holds while no read is issued.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

[verif/wwa_checker.sv]
// ---------------------------------------------------------------------------
// Weighted work apportioner checker
// Watches the input, output and configuration ports of the core, keeps its
// own copy of the worker table, predicts the results of every accepted item
// and compares each accepted result field by field with the oldest one.
// ---------------------------------------------------------------------------
`timescale 1ns / 100ps

module wwa_checker
  import wwa_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  input  logic      in_ready_i,
  input  in_item_t  in_data_i,
  input  logic      out_valid_i,
  input  logic      out_ready_i,
  input  out_item_t out_data_i,
  input  logic      cfg_we_i,
  input  logic [4:0] cfg_wdata_i,
  output int        fail_count_o,
  output int        pending_o
);

  localparam int TABLE_DEPTH = 16;

  logic [31:0] wt_id      [TABLE_DEPTH];
  logic [2:0]  wt_backend [TABLE_DEPTH];
  logic [31:0] wt_rate    [TABLE_DEPTH];
  int          wt_count;
  logic [4:0]  max_assign;
  out_item_t   pending_results[$];

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("[%0t] mismatch %s: got %0h expected %0h", $realtime, what, got, want);
    fail_count_o++;
  endtask

  function automatic out_item_t status_only(logic st);
    out_item_t r;
    r        = '0;
    r.status = st;
    r.last   = 1'b1;
    return r;
  endfunction

  // Apply one item to the table and queue the results it causes.
  function automatic void apportion_item(in_item_t it);
    logic [31:0] rt;
    int          hit;
    int          cand[TABLE_DEPTH];
    logic [63:0] units[TABLE_DEPTH];
    logic [63:0] rem[TABLE_DEPTH];
    bit          bumped[TABLE_DEPTH];
    int          nc;
    int          cap;
    int          best;
    int          n;
    logic [63:0] sum;
    logic [63:0] assigned;
    logic [63:0] first;
    logic [63:0] prod;
    out_item_t   r;
    out_item_t   rows[$];
    rt  = (it.rate == 0) ? 32'd1 : it.rate;
    hit = -1;
    for (int i = 0; i < wt_count; i++) begin
      if (wt_id[i] == it.wrk_id) hit = i;
    end
    case (it.op)
      OP_REGISTER: begin
        if (it.wrk_id == 0) begin
          pending_results.push_back(status_only(1'b1));
        end else if (hit >= 0) begin
          wt_backend[hit] = it.backend;
          wt_rate[hit]    = rt;
          pending_results.push_back(status_only(1'b0));
        end else if (wt_count >= TABLE_DEPTH) begin
          pending_results.push_back(status_only(1'b1));
        end else begin
          wt_id[wt_count]      = it.wrk_id;
          wt_backend[wt_count] = it.backend;
          wt_rate[wt_count]    = rt;
          wt_count++;
          pending_results.push_back(status_only(1'b0));
        end
      end
      OP_UNREGISTER: begin
        if (it.wrk_id == 0 || hit < 0) begin
          pending_results.push_back(status_only(1'b1));
        end else begin
          // Move the last row into the freed slot.
          wt_id[hit]      = wt_id[wt_count-1];
          wt_backend[hit] = wt_backend[wt_count-1];
          wt_rate[hit]    = wt_rate[wt_count-1];
          wt_count--;
          pending_results.push_back(status_only(1'b0));
        end
      end
      OP_SCHEDULE: begin
        nc  = 0;
        sum = '0;
        cap = (max_assign > RESULT_LIMIT) ? RESULT_LIMIT : max_assign;
        for (int i = 0; i < wt_count; i++) begin
          if (wt_backend[i] != 0) begin
            cand[nc] = i;
            nc++;
            sum += wt_rate[i];
          end
        end
        if (it.work_total == 0 || nc == 0) begin
          pending_results.push_back(status_only(1'b0));
        end else if (nc > cap) begin
          pending_results.push_back(status_only(1'b1));
        end else begin
          assigned = '0;
          for (int k = 0; k < nc; k++) begin
            prod      = 64'(it.work_total) * 64'(wt_rate[cand[k]]);
            units[k]  = prod / sum;
            rem[k]    = prod % sum;
            bumped[k] = 1'b0;
            assigned += units[k];
          end
          // Hand out leftovers by largest remainder, lower id on a tie.
          while (assigned < 64'(it.work_total)) begin
            best = -1;
            for (int k = 0; k < nc; k++) begin
              if (!bumped[k] && (best < 0 || rem[k] > rem[best] ||
                  (rem[k] == rem[best] && wt_id[cand[k]] < wt_id[cand[best]])))
                best = k;
            end
            if (best < 0) break;
            units[best]++;
            bumped[best] = 1'b1;
            assigned++;
          end
          first = '0;
          for (int k = 0; k < nc; k++) begin
            if (units[k] != 0) begin
              r                  = '0;
              r.assigned_worker  = wt_id[cand[k]];
              r.assigned_backend = wt_backend[cand[k]];
              r.range_base       = first[31:0];
              r.range_len        = units[k][31:0];
              r.assigned_rate    = wt_rate[cand[k]];
              first             += units[k];
              rows.push_back(r);
            end
          end
          n = rows.size();
          foreach (rows[k]) begin
            rows[k].assignment_total = 5'(n);
            rows[k].last             = (k == n - 1);
            pending_results.push_back(rows[k]);
          end
        end
      end
      default: pending_results.push_back(status_only(1'b1));
    endcase
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    out_item_t want;
    if (!rst_ni) begin
      wt_count     = 0;
      max_assign   = CFG_RESET;
      fail_count_o = 0;
      pending_results.delete();
    end else begin
      if (cfg_we_i) max_assign = cfg_wdata_i;
      if (in_valid_i && in_ready_i) apportion_item(in_data_i);
      if (out_valid_i && out_ready_i) begin
        if (pending_results.size() == 0) begin
          report_mismatch("unexpected result", 64'(out_data_i.assigned_worker), 64'd0);
        end else begin
          want = pending_results.pop_front();
          if (out_data_i.status !== want.status)
            report_mismatch("status", 64'(out_data_i.status), 64'(want.status));
          if (out_data_i.assigned_worker !== want.assigned_worker)
            report_mismatch("assigned_worker", 64'(out_data_i.assigned_worker),
                            64'(want.assigned_worker));
          if (out_data_i.assigned_backend !== want.assigned_backend)
            report_mismatch("assigned_backend", 64'(out_data_i.assigned_backend),
                            64'(want.assigned_backend));
          if (out_data_i.range_base !== want.range_base)
            report_mismatch("range_base", 64'(out_data_i.range_base),
                            64'(want.range_base));
          if (out_data_i.range_len !== want.range_len)
            report_mismatch("range_len", 64'(out_data_i.range_len),
                            64'(want.range_len));
          if (out_data_i.assigned_rate !== want.assigned_rate)
            report_mismatch("assigned_rate", 64'(out_data_i.assigned_rate),
                            64'(want.assigned_rate));
          if (out_data_i.assignment_total !== want.assignment_total)
            report_mismatch("assignment_total", 64'(out_data_i.assignment_total),
                            64'(want.assignment_total));
          if (out_data_i.last !== want.last)
            report_mismatch("last", 64'(out_data_i.last), 64'(want.last));
        end
      end
    end
    pending_o = pending_results.size();
  end

endmodule

[verif/testbench.sv]
// ---------------------------------------------------------------------------
// Weighted work apportioner testbench
// Drives directed and random register, unregister and schedule items through
// the core under several assignment limits, with random stalls on both
// channels, and takes the verdict from the checker's failure count.
// ---------------------------------------------------------------------------
`timescale 1ns / 100ps

module testbench;
  import wwa_pkg::*;

  // Cycle limit for the watchdog; this is far beyond any run.
  localparam int CYCLE_LIMIT = 3000000;

  logic      clk_i;
  logic      rst_ni;
  logic      in_valid;
  logic      in_ready;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_ready;
  out_item_t out_data;
  logic      cfg_we;
  logic [4:0] cfg_wdata;
  int        fail_count;
  int        pending;
  int        cycles;
  bit        stalls_on;

  weighted_work_apportioner_core dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata)
  );

  wwa_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid),
    .in_ready_i   (in_ready),
    .in_data_i    (in_data),
    .out_valid_i  (out_valid),
    .out_ready_i  (out_ready),
    .out_data_i   (out_data),
    .cfg_we_i     (cfg_we),
    .cfg_wdata_i  (cfg_wdata),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Stop a hung run.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Stall the result side at random with a chance of 22 in a hundred, unless stalls are off.
  always @(negedge clk_i) begin
    out_ready <= stalls_on ? ($urandom_range(99) >= 22) : 1'b1;
  end

  // Present one item and hold it until it is accepted; idle first at random.
  // Enter and leave at a falling edge.
  task automatic send_item(in_item_t it);
    if (stalls_on && $urandom_range(99) < 22) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk_i);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk_i); while (!in_ready);
    @(negedge clk_i);
  endtask

  task automatic send_fields(logic [1:0] op, logic [31:0] id, logic [2:0] be,
                             logic [31:0] rate, logic [31:0] total);
    in_item_t it;
    it.op         = op;
    it.wrk_id     = id;
    it.backend    = be;
    it.rate       = rate;
    it.work_total = total;
    send_item(it);
  endtask

  // Drain all results, let the core settle, then write the limit register.
  task automatic set_limit(logic [4:0] value);
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (64) @(negedge clk_i);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk_i);
    cfg_we    <= 1'b0;
  endtask

  // Random item: ids mostly from a pool a bit larger than the table, so
  // updates, removals and a full table all occur.
  function automatic in_item_t random_item();
    in_item_t it;
    int       pick;
    pick = $urandom_range(99);
    if (pick < 35)      it.op = OP_REGISTER;
    else if (pick < 55) it.op = OP_UNREGISTER;
    else if (pick < 95) it.op = OP_SCHEDULE;
    else                it.op = OP_RESERVED;
    pick = $urandom_range(99);
    if (pick < 80)      it.wrk_id = $urandom_range(1, 20);
    else if (pick < 88) it.wrk_id = '0;
    else if (pick < 96) it.wrk_id = $urandom;
    else                it.wrk_id = 32'hFFFF_FFF0 + $urandom_range(15);
    it.backend = ($urandom_range(99) < 75) ? 3'($urandom_range(1, 7)) : 3'd0;
    pick = $urandom_range(99);
    if (pick < 50)      it.rate = $urandom_range(0, 12);
    else if (pick < 90) it.rate = $urandom;
    else                it.rate = 32'hFFFF_FFFF;
    pick = $urandom_range(99);
    if (pick < 8)       it.work_total = '0;
    else if (pick < 75) it.work_total = $urandom_range(1, 60);
    else if (pick < 95) it.work_total = $urandom;
    else                it.work_total = 32'hFFFF_FFFF;
    return it;
  endfunction

  task automatic random_phase(int count);
    repeat (count) send_item(random_item());
  endtask

  initial begin
    stalls_on = 1'b1;
    rst_ni    = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    cfg_we    = 1'b0;
    cfg_wdata = '0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed: empty table, bad codes and ids.
    send_fields(OP_RESERVED, 32'd7, 3'd1, 32'd1, 32'd5);
    send_fields(OP_SCHEDULE, 32'd0, 3'd0, 32'd0, 32'd10);
    send_fields(OP_REGISTER, 32'd0, 3'd1, 32'd5, 32'd0);
    send_fields(OP_UNREGISTER, 32'd0, 3'd0, 32'd0, 32'd0);
    send_fields(OP_UNREGISTER, 32'd9, 3'd0, 32'd0, 32'd0);
    // Equal rates with one leftover: the tie goes to the lower id.
    send_fields(OP_REGISTER, 32'd5, 3'd2, 32'd4, 32'd0);
    send_fields(OP_REGISTER, 32'd3, 3'd7, 32'd4, 32'd0);
    send_fields(OP_SCHEDULE, 32'd0, 3'd0, 32'd0, 32'd1);
    send_fields(OP_SCHEDULE, 32'd0, 3'd0, 32'd0, 32'd0);
    // Zero rate counts as one; update an existing id; widest values.
    send_fields(OP_REGISTER, 32'hFFFF_FFFF, 3'd4, 32'd0, 32'd0);
    send_fields(OP_REGISTER, 32'd5, 3'd1, 32'hFFFF_FFFF, 32'd0);
    send_fields(OP_SCHEDULE, 32'hFFFF_FFFF, 3'd7, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    // Non-candidate worker only: drop the others, keep one with no backend.
    send_fields(OP_REGISTER, 32'd3, 3'd0, 32'd9, 32'd0);
    send_fields(OP_UNREGISTER, 32'd5, 3'd0, 32'd0, 32'd0);
    send_fields(OP_UNREGISTER, 32'hFFFF_FFFF, 3'd0, 32'd0, 32'd0);
    send_fields(OP_SCHEDULE, 32'd0, 3'd0, 32'd0, 32'd100);
    // Fill the table, overflow it, then schedule over its sixteen rows.
    for (int i = 1; i <= 16; i++)
      send_fields(OP_REGISTER, 32'(100 + i), 3'(1 + i % 7), 32'(i), 32'd0);
    send_fields(OP_REGISTER, 32'd200, 3'd1, 32'd1, 32'd0);
    send_fields(OP_SCHEDULE, 32'd0, 3'd0, 32'd0, 32'd1000);

    // Limit written above 16 acts as 16; then the extremes and a small cap.
    set_limit(5'd31);
    send_fields(OP_SCHEDULE, 32'd0, 3'd0, 32'd0, 32'd7);
    random_phase(80);
    set_limit(5'd0);
    random_phase(45);
    set_limit(5'd3);
    stalls_on = 1'b0;
    random_phase(70);
    stalls_on = 1'b1;
    set_limit(5'd16);
    random_phase(80);
    in_valid <= 1'b0;

    while (pending != 0) @(negedge clk_i);
    repeat (200) @(negedge clk_i);
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
